FILE: rtl/tag_arg_string_tokenizer_core_assert.svh
// Assertion macros for the tokenizer core.
`ifndef TAG_ARG_STRING_TOKENIZER_CORE_ASSERT_SVH
`define TAG_ARG_STRING_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TASTOK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tokenizer assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TASTOK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tokenizer assertion failed");

`endif

FILE: rtl/tastok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tastok_pkg;

  localparam int MAX_ARGS_DEF = 16;
  localparam int MAX_TAGS_DEF = 256;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    KIND_HELD      = 3'd0,
    KIND_NAME      = 3'd1,
    KIND_ARG       = 3'd2,
    KIND_TAG_SEP   = 3'd3,
    KIND_ARG_SEP   = 3'd4,
    KIND_DROP_SEP  = 3'd5,
    KIND_DROP_CHAR = 3'd6
  } kind_t;

  typedef struct packed {
    logic esc;
    logic in_name;
    logic name_seen;
    logic discarding;
    logic ok;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    esc: 1'b0, in_name: 1'b1, name_seen: 1'b0, discarding: 1'b0, ok: 1'b1
  };

  typedef struct packed {
    logic [7:0] out_char;
    kind_t      kind;
    logic [7:0] tag_index;
    logic [5:0] arg_index;
    logic       all_ok;
  } res_t;

  function automatic logic name_char_ok(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_COLON});
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tag_arg_string_tokenizer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Key/value display string tokenizer (name=arg,arg;name=...). Takes one
// character per s_ beat and gives one classified result per m_ beat, at one
// character per clock while m_tready does not hold back the output. A
// character goes into an input register, is classified against the running
// parse state by the combinational step logic, and its result lands in an
// output register, which holds it while m_tready is low. The parse state
// loop (escape, name, tag and argument counters, ok flag) closes through the
// step logic. A beat with tlast carries the final all_ok and returns the
// parser to its reset state.

`include "tag_arg_string_tokenizer_core_assert.svh"

module tag_arg_string_tokenizer_core #(
  parameter int MAX_ARGS = tastok_pkg::MAX_ARGS_DEF,
  parameter int MAX_TAGS = tastok_pkg::MAX_TAGS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] ch
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_char, [15:8] tag_index,
                                      // [21:16] arg_index, [23:22] zero
  output logic [3:0]       m_tuser,   // [2:0] kind, [3] all_ok
  output logic             m_tlast
);

  localparam int TAG_W = $clog2(MAX_TAGS);
  localparam int ARG_W = $clog2(MAX_ARGS + 1);

  logic               in_valid;
  logic [7:0]         in_ch;
  logic               in_last;
  logic               adv;

  tastok_pkg::flags_t flags;
  tastok_pkg::flags_t flags_next;
  logic [TAG_W-1:0]   tag_count;
  logic [TAG_W-1:0]   tag_count_next;
  logic [ARG_W-1:0]   arg_count;
  logic [ARG_W-1:0]   arg_count_next;
  tastok_pkg::res_t   res_next;

  tastok_pkg::res_t   res;
  logic               out_valid;
  logic               out_last;

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_ch   <= s_tdata;
      in_last <= s_tlast;
    end
  end

  tastok_step #(
    .MAX_ARGS (MAX_ARGS),
    .MAX_TAGS (MAX_TAGS)
  ) u_step (
    .ch             (in_ch),
    .last           (in_last),
    .flags          (flags),
    .tag_count      (tag_count),
    .arg_count      (arg_count),
    .flags_next     (flags_next),
    .tag_count_next (tag_count_next),
    .arg_count_next (arg_count_next),
    .res            (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= tastok_pkg::FLAGS_RESET;
      tag_count <= '0;
      arg_count <= '0;
    end else if (adv) begin
      flags     <= flags_next;
      tag_count <= tag_count_next;
      arg_count <= arg_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (adv) begin
      res      <= res_next;
      out_last <= in_last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, res.arg_index, res.tag_index, res.out_char};
  assign m_tuser  = {res.all_ok, res.kind};
  assign m_tlast  = out_last;

  `TASTOK_ASSERT_NOW(a_held_escape_shape,
    m_tvalid && m_tuser[2:0] == tastok_pkg::KIND_HELD,
    m_tdata[7:0] == 8'd0 && !m_tlast)
  `TASTOK_ASSERT_NEXT(a_restart_after_last,
    adv && in_last,
    flags == tastok_pkg::FLAGS_RESET && tag_count == '0 && arg_count == '0)
  `TASTOK_ASSERT_NEXT(a_ok_sticks_low,
    adv && !in_last && !flags_next.ok,
    !flags.ok)

endmodule

`default_nettype wire

FILE: rtl/tastok_step.sv
`timescale 1ns / 1ps
`default_nettype none

module tastok_step #(
  parameter int MAX_ARGS = tastok_pkg::MAX_ARGS_DEF,
  parameter int MAX_TAGS = tastok_pkg::MAX_TAGS_DEF,
  localparam int TAG_W = $clog2(MAX_TAGS),
  localparam int ARG_W = $clog2(MAX_ARGS + 1)
) (
  input  wire logic [7:0]        ch,
  input  wire logic              last,
  input  wire tastok_pkg::flags_t flags,
  input  wire logic [TAG_W-1:0]  tag_count,
  input  wire logic [ARG_W-1:0]  arg_count,
  output tastok_pkg::flags_t     flags_next,
  output logic [TAG_W-1:0]       tag_count_next,
  output logic [ARG_W-1:0]       arg_count_next,
  output tastok_pkg::res_t       res
);

  localparam logic [TAG_W-1:0] TAG_MAX = TAG_W'(MAX_TAGS - 1);
  localparam logic [ARG_W-1:0] ARG_LIM = ARG_W'(MAX_ARGS);

  tastok_pkg::flags_t nx;
  logic [TAG_W-1:0]   nx_tag;
  logic [ARG_W-1:0]   nx_arg;
  logic [ARG_W-1:0]   arg_m1;
  logic [TAG_W+7:0]   tag_ext;
  logic [ARG_W+5:0]   arg_ext;
  logic               close_bad;
  logic [7:0]         out_ch;
  tastok_pkg::kind_t  kind;

  assign close_bad = flags.in_name && !flags.name_seen;

  always_comb begin
    nx     = flags;
    nx.esc = 1'b0;
    nx_tag = tag_count;
    nx_arg = arg_count;
    out_ch = ch;
    kind   = tastok_pkg::KIND_ARG;
    if (!flags.esc && ch == tastok_pkg::CH_BSL && !last) begin
      nx.esc = 1'b1;
      out_ch = 8'd0;
      kind   = tastok_pkg::KIND_HELD;
    end else if (!flags.esc && ch == tastok_pkg::CH_SEMI) begin
      if (close_bad) nx.ok = 1'b0;
      if (tag_count >= TAG_MAX) nx.ok = 1'b0;
      else nx_tag = tag_count + TAG_W'(1);
      nx.in_name    = 1'b1;
      nx.name_seen  = 1'b0;
      nx_arg        = '0;
      nx.discarding = 1'b0;
      kind          = tastok_pkg::KIND_TAG_SEP;
    end else if (!flags.esc && ch == tastok_pkg::CH_EQ) begin
      if (close_bad) nx.ok = 1'b0;
      nx.in_name    = 1'b0;
      nx_arg        = ARG_W'(1);
      nx.discarding = 1'b0;
      kind          = tastok_pkg::KIND_ARG_SEP;
    end else if (!flags.esc && ch == tastok_pkg::CH_COMMA) begin
      if (close_bad) nx.ok = 1'b0;
      nx.in_name = 1'b0;
      if (arg_count >= ARG_LIM) begin
        nx.ok         = 1'b0;
        nx.discarding = 1'b1;
        kind          = tastok_pkg::KIND_DROP_SEP;
      end else begin
        nx_arg        = arg_count + ARG_W'(1);
        nx.discarding = 1'b0;
        kind          = tastok_pkg::KIND_ARG_SEP;
      end
    end else if (flags.discarding) begin
      kind = tastok_pkg::KIND_DROP_CHAR;
    end else if (flags.in_name) begin
      nx.name_seen = 1'b1;
      if (!tastok_pkg::name_char_ok(ch)) nx.ok = 1'b0;
      kind = tastok_pkg::KIND_NAME;
    end
    if (last && nx.in_name && !nx.name_seen) nx.ok = 1'b0;
  end

  assign arg_m1  = nx_arg - ARG_W'(1);
  assign tag_ext = {8'd0, nx_tag};
  assign arg_ext = (nx.in_name || nx_arg == '0) ? '0 : {6'd0, arg_m1};
  assign res     = '{
    out_char:  out_ch,
    kind:      kind,
    tag_index: tag_ext[7:0],
    arg_index: arg_ext[5:0],
    all_ok:    nx.ok
  };

  // end of string returns to the reset state
  assign flags_next     = last ? tastok_pkg::FLAGS_RESET : nx;
  assign tag_count_next = last ? '0 : nx_tag;
  assign arg_count_next = last ? '0 : nx_arg;

endmodule

`default_nettype wire
